### rtl/assert_macros.svh
// Shared assertion macros for the text word decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### rtl/ztwd_pkg.sv
package ztwd_pkg;

   // Slot kinds of a decoded z-character.
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_CHAR   = 2'd1;
   localparam logic [1:0] KIND_ABBREV = 2'd2;

   // Alphabet selected for the next z-character.
   localparam logic [1:0] SHIFT_LOWER = 2'd0;
   localparam logic [1:0] SHIFT_UPPER = 2'd1;
   localparam logic [1:0] SHIFT_PUNCT = 2'd2;

   // No abbreviation is waiting for its second z-character.
   localparam logic [1:0] NO_BANK = 2'd0;

   // Special z-characters.
   localparam logic [4:0] ZCHAR_SPACE     = 5'd0;
   localparam logic [4:0] ZCHAR_ABBREV_LO = 5'd1;
   localparam logic [4:0] ZCHAR_ABBREV_HI = 5'd3;
   localparam logic [4:0] ZCHAR_SHIFT_UP  = 5'd4;
   localparam logic [4:0] ZCHAR_SHIFT_PCT = 5'd5;
   localparam logic [4:0] ZCHAR_FIRST_LTR = 5'd6;

   localparam logic [7:0] ASCII_SPACE   = 8'h20;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;

   localparam int CODE_WORD_W = 16;
   localparam int VALUE_W     = 8;
   localparam int KIND_W      = 2;

   // Result of decoding one z-character, with the state it leaves behind.
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      logic [1:0]         shift;
      logic [1:0]         bank;
   } zchar_result_type;

   // Punctuation alphabet, indexed by z-char minus six.
   function automatic logic [7:0] punct_char(input logic [4:0] idx);
      logic [7:0] c;
      case (idx)
         5'd0:    c = 8'h20; // space
         5'd1:    c = 8'h5E; // ^
         5'd2:    c = 8'h30;
         5'd3:    c = 8'h31;
         5'd4:    c = 8'h32;
         5'd5:    c = 8'h33;
         5'd6:    c = 8'h34;
         5'd7:    c = 8'h35;
         5'd8:    c = 8'h36;
         5'd9:    c = 8'h37;
         5'd10:   c = 8'h38;
         5'd11:   c = 8'h39;
         5'd12:   c = 8'h2E; // .
         5'd13:   c = 8'h2C; // ,
         5'd14:   c = 8'h21; // !
         5'd15:   c = 8'h3F; // ?
         5'd16:   c = 8'h5F; // _
         5'd17:   c = 8'h23; // #
         5'd18:   c = 8'h27; // single quote
         5'd19:   c = 8'h22; // double quote
         5'd20:   c = 8'h2F; // /
         5'd21:   c = 8'h5C; // backslash
         5'd22:   c = 8'h2D; // -
         5'd23:   c = 8'h3A; // :
         5'd24:   c = 8'h28; // (
         5'd25:   c = 8'h29; // )
         default: c = 8'h20;
      endcase
      return c;
   endfunction

endpackage

### rtl/ztwd_req_if.sv
// Input channel: one packed text word per item.
interface ztwd_req_if;
   logic                              valid;
   logic                              ready;
   logic [ztwd_pkg::CODE_WORD_W-1:0] code_word;
   logic                              new_string;

   modport source (output valid, output code_word, output new_string, input ready);
   modport sink   (input valid, input code_word, input new_string, output ready);
endinterface

### rtl/ztwd_rsp_if.sv
// Result channel: three decoded slots and the end mark per item.
interface ztwd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ztwd_pkg::KIND_W-1:0]  slot0_kind;
   logic [ztwd_pkg::VALUE_W-1:0] slot0_value;
   logic [ztwd_pkg::KIND_W-1:0]  slot1_kind;
   logic [ztwd_pkg::VALUE_W-1:0] slot1_value;
   logic [ztwd_pkg::KIND_W-1:0]  slot2_kind;
   logic [ztwd_pkg::VALUE_W-1:0] slot2_value;
   logic                          string_end;

   modport source (output valid, output slot0_kind, output slot0_value,
                   output slot1_kind, output slot1_value,
                   output slot2_kind, output slot2_value,
                   output string_end, input ready);
   modport sink   (input valid, input slot0_kind, input slot0_value,
                   input slot1_kind, input slot1_value,
                   input slot2_kind, input slot2_value,
                   input string_end, output ready);
endinterface

### rtl/zscii_text_word_decoder.sv
// Decodes Z-machine version 3 packed text words, one word per item, into three
// result slots (a character, an abbreviation number, or empty) plus the end
// mark. A word enters an input register, is decoded combinationally and lands in
// the result register, so the block takes one item per cycle while its results
// are taken. A result turns valid as its word moves from the input register into
// the result register; a stalled result holds the input register, and
// then the input stalls too. The shift and abbreviation state that carries
// between words is updated as a decoded word moves into the result register;
// assert new_string on the first word of each string.
`include "assert_macros.svh"

module zscii_text_word_decoder (
   input  logic       clock,
   input  logic       reset,
   ztwd_req_if.sink   req_if,
   ztwd_rsp_if.source rsp_if
);

   // Decode one z-character given the current shift and abbreviation state.
   function automatic ztwd_pkg::zchar_result_type decode_zchar(
      input logic [4:0] z,
      input logic [1:0] shift,
      input logic [1:0] bank
   );
      ztwd_pkg::zchar_result_type r;
      logic [4:0] idx;
      logic [1:0] bank_base;
      r.kind  = ztwd_pkg::KIND_NONE;
      r.value = '0;
      r.shift = shift;
      r.bank  = bank;
      idx       = z - ztwd_pkg::ZCHAR_FIRST_LTR;
      bank_base = bank - 2'd1;
      if (bank != ztwd_pkg::NO_BANK) begin
         r.kind  = ztwd_pkg::KIND_ABBREV;
         r.value = {1'b0, bank_base, z};
         r.bank  = ztwd_pkg::NO_BANK;
         r.shift = ztwd_pkg::SHIFT_LOWER;
      end else if (z == ztwd_pkg::ZCHAR_SPACE) begin
         r.kind  = ztwd_pkg::KIND_CHAR;
         r.value = ztwd_pkg::ASCII_SPACE;
         r.shift = ztwd_pkg::SHIFT_LOWER;
      end else if (z inside {[ztwd_pkg::ZCHAR_ABBREV_LO:ztwd_pkg::ZCHAR_ABBREV_HI]}) begin
         r.bank  = z[1:0];
         r.shift = ztwd_pkg::SHIFT_LOWER;
      end else if (z == ztwd_pkg::ZCHAR_SHIFT_UP) begin
         r.shift = ztwd_pkg::SHIFT_UPPER;
      end else if (z == ztwd_pkg::ZCHAR_SHIFT_PCT) begin
         r.shift = ztwd_pkg::SHIFT_PUNCT;
      end else begin
         r.kind = ztwd_pkg::KIND_CHAR;
         case (shift)
            ztwd_pkg::SHIFT_LOWER: r.value = ztwd_pkg::ASCII_LOWER_A + {3'b000, idx};
            ztwd_pkg::SHIFT_UPPER: r.value = ztwd_pkg::ASCII_UPPER_A + {3'b000, idx};
            default:               r.value = ztwd_pkg::punct_char(idx);
         endcase
         r.shift = ztwd_pkg::SHIFT_LOWER;
      end
      return r;
   endfunction

   // Input register.
   logic                              in_valid_ff;
   logic [ztwd_pkg::CODE_WORD_W-1:0] word_ff;
   logic                              new_string_ff;

   // Carried decode state.
   logic [1:0] shift_ff, shift_in;
   logic [1:0] bank_ff, bank_in;

   // Result register.
   logic                          out_valid_ff;
   logic [ztwd_pkg::KIND_W-1:0]  kind0_ff, kind1_ff, kind2_ff;
   logic [ztwd_pkg::VALUE_W-1:0] value0_ff, value1_ff, value2_ff;
   logic                          end_ff;

   logic advance;
   logic load;
   logic [1:0] shift_start, bank_start;
   ztwd_pkg::zchar_result_type r0, r1, r2;

   // The decoded word moves on when the result register is free or draining.
   assign advance = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign load = req_if.valid && req_if.ready;

   // Three chained z-character decodes on the registered word.
   always_comb begin
      shift_start = new_string_ff ? ztwd_pkg::SHIFT_LOWER : shift_ff;
      bank_start  = new_string_ff ? ztwd_pkg::NO_BANK : bank_ff;
      r0 = decode_zchar(word_ff[14:10], shift_start, bank_start);
      r1 = decode_zchar(word_ff[9:5], r0.shift, r0.bank);
      r2 = decode_zchar(word_ff[4:0], r1.shift, r1.bank);
      shift_in = advance ? r2.shift : shift_ff;
      bank_in  = advance ? r2.bank : bank_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         shift_ff     <= ztwd_pkg::SHIFT_LOWER;
         bank_ff      <= ztwd_pkg::NO_BANK;
      end else begin
         in_valid_ff <= load || (in_valid_ff && !advance);
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
         shift_ff <= shift_in;
         bank_ff  <= bank_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff       <= req_if.code_word;
         new_string_ff <= req_if.new_string;
      end
      if (advance) begin
         kind0_ff  <= r0.kind;
         value0_ff <= r0.value;
         kind1_ff  <= r1.kind;
         value1_ff <= r1.value;
         kind2_ff  <= r2.kind;
         value2_ff <= r2.value;
         end_ff    <= word_ff[15];
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.slot0_kind  = kind0_ff;
   assign rsp_if.slot0_value = value0_ff;
   assign rsp_if.slot1_kind  = kind1_ff;
   assign rsp_if.slot1_value = value1_ff;
   assign rsp_if.slot2_kind  = kind2_ff;
   assign rsp_if.slot2_value = value2_ff;
   assign rsp_if.string_end  = end_ff;

   // An abbreviation start always clears the shift, so both never pend together.
   `ASSERT_SAME(a_state_exclusive, clock, reset, bank_ff != ztwd_pkg::NO_BANK,
                shift_ff == ztwd_pkg::SHIFT_LOWER)
   // The unused shift code is never stored.
   `ASSERT_SAME(a_shift_code, clock, reset, 1'b1, shift_ff <= ztwd_pkg::SHIFT_PUNCT)
   // Abbreviation numbers stay below 96.
   `ASSERT_SAME(a_abbrev_range, clock, reset,
                out_valid_ff && kind1_ff == ztwd_pkg::KIND_ABBREV, value1_ff < 8'd96)
   // A decoded word reaches the result register in the next cycle.
   `ASSERT_NEXT(a_advance_valid, clock, reset, advance, out_valid_ff)

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

   // One decoded z-character slot and one decoded text word.
   typedef struct packed {
      logic [ztwd_pkg::KIND_W-1:0]  kind;
      logic [ztwd_pkg::VALUE_W-1:0] value;
   } slot_type;

   typedef struct packed {
      slot_type [2:0] slot;
      logic           fin;
   } decoded_word_type;

   // Punctuation alphabet, first character at the left.
   localparam logic [8*26-1:0] PUNCT_ROW = " ^0123456789.,!?_#'\"/\\-:()";
   localparam int LIMIT_NS = 2_000_000;
   localparam int DRAIN_CYCLES = 8;

   logic clock;
   logic reset;

   ztwd_req_if req_bus ();
   ztwd_rsp_if rsp_bus ();

   zscii_text_word_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // Alphabet and abbreviation bank that carry from word to word.
   logic [1:0] alpha_sel;
   logic [1:0] open_bank;

   decoded_word_type due_words[$];
   int mismatches;
   bit req_idle;
   bit rsp_idle;
   int rsp_hold;

   always #2 clock = ~clock;

   // Decode one z-character and advance the carried state.
   function automatic slot_type zchar_to_slot(input logic [4:0] z);
      slot_type s;
      logic [1:0] bank_ofs;
      int letter;
      s.kind = ztwd_pkg::KIND_NONE;
      s.value = '0;
      bank_ofs = open_bank - 2'd1;
      letter = int'(z) - int'(ztwd_pkg::ZCHAR_FIRST_LTR);
      if (open_bank != ztwd_pkg::NO_BANK) begin
         s.kind = ztwd_pkg::KIND_ABBREV;
         s.value = {1'b0, bank_ofs, z};
         open_bank = ztwd_pkg::NO_BANK;
         alpha_sel = ztwd_pkg::SHIFT_LOWER;
      end else if (z == ztwd_pkg::ZCHAR_SPACE) begin
         s.kind = ztwd_pkg::KIND_CHAR;
         s.value = ztwd_pkg::ASCII_SPACE;
         alpha_sel = ztwd_pkg::SHIFT_LOWER;
      end else if (z < ztwd_pkg::ZCHAR_SHIFT_UP) begin
         open_bank = z[1:0];
         alpha_sel = ztwd_pkg::SHIFT_LOWER;
      end else if (z == ztwd_pkg::ZCHAR_SHIFT_UP) begin
         alpha_sel = ztwd_pkg::SHIFT_UPPER;
      end else if (z == ztwd_pkg::ZCHAR_SHIFT_PCT) begin
         alpha_sel = ztwd_pkg::SHIFT_PUNCT;
      end else begin
         s.kind = ztwd_pkg::KIND_CHAR;
         if (alpha_sel == ztwd_pkg::SHIFT_LOWER) begin
            s.value = ztwd_pkg::ASCII_LOWER_A + 8'(letter);
         end else if (alpha_sel == ztwd_pkg::SHIFT_UPPER) begin
            s.value = ztwd_pkg::ASCII_UPPER_A + 8'(letter);
         end else begin
            // Shift code three never arises; it would read punctuation too.
            s.value = PUNCT_ROW[8*(25 - letter) +: 8];
         end
         alpha_sel = ztwd_pkg::SHIFT_LOWER;
      end
      return s;
   endfunction

   // Expected result of one accepted text word.
   function automatic decoded_word_type decode_text_word(input logic [15:0] w,
                                                         input logic ns);
      decoded_word_type r;
      if (ns) begin
         alpha_sel = ztwd_pkg::SHIFT_LOWER;
         open_bank = ztwd_pkg::NO_BANK;
      end
      for (int k = 0; k < 3; k++) begin
         r.slot[k] = zchar_to_slot(w[14-5*k -: 5]);
      end
      r.fin = w[15];
      return r;
   endfunction

   function automatic logic [15:0] pack_word(input logic fin, input logic [4:0] a,
                                              input logic [4:0] b, input logic [4:0] c);
      return {fin, a, b, c};
   endfunction

   // Letters most of the time, so strings get past shifts and abbreviations.
   function automatic logic [4:0] rand_zchar();
      if ($urandom_range(0, 3) == 0) begin
         return 5'($urandom_range(0, 31));
      end
      if ($urandom_range(0, 1) == 0) begin
         return 5'($urandom_range(0, 5));
      end
      return 5'($urandom_range(6, 31));
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   // Offer one word, after a random gap while req_idle is set, and record its expected decode on acceptance.
   task automatic send_word(input logic [15:0] w, input logic ns);
      int gap;
      gap = req_idle ? $urandom_range(0, 7) : 0;
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.code_word  <= w;
      req_bus.new_string <= ns;
      do @(posedge clock); while (!req_bus.ready);
      due_words.push_back(decode_text_word(w, ns));
   endtask

   // Receiver: a random stall per item while rsp_idle is set, or a long hold when one is requested.
   initial begin
      int stall;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (rsp_hold > 0) begin
            stall = rsp_hold;
            rsp_hold = 0;
         end else begin
            stall = rsp_idle ? $urandom_range(0, 7) : 0;
         end
         repeat (stall) begin
            rsp_bus.ready <= 1'b0;
            @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // Compare every accepted result with the oldest expected decode.
   always @(posedge clock) begin
      decoded_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (due_words.size() == 0) begin
            report_mismatch("result item arrived with none expected");
         end else begin
            want = due_words.pop_front();
            if (rsp_bus.slot0_kind !== want.slot[0].kind)
               report_mismatch($sformatf("slot0_kind got %0d want %0d",
                                         rsp_bus.slot0_kind, want.slot[0].kind));
            if (rsp_bus.slot0_value !== want.slot[0].value)
               report_mismatch($sformatf("slot0_value got %0d want %0d",
                                         rsp_bus.slot0_value, want.slot[0].value));
            if (rsp_bus.slot1_kind !== want.slot[1].kind)
               report_mismatch($sformatf("slot1_kind got %0d want %0d",
                                         rsp_bus.slot1_kind, want.slot[1].kind));
            if (rsp_bus.slot1_value !== want.slot[1].value)
               report_mismatch($sformatf("slot1_value got %0d want %0d",
                                         rsp_bus.slot1_value, want.slot[1].value));
            if (rsp_bus.slot2_kind !== want.slot[2].kind)
               report_mismatch($sformatf("slot2_kind got %0d want %0d",
                                         rsp_bus.slot2_kind, want.slot[2].kind));
            if (rsp_bus.slot2_value !== want.slot[2].value)
               report_mismatch($sformatf("slot2_value got %0d want %0d",
                                         rsp_bus.slot2_value, want.slot[2].value));
            if (rsp_bus.string_end !== want.fin)
               report_mismatch($sformatf("string_end got %0d want %0d",
                                         rsp_bus.string_end, want.fin));
         end
      end
   end

   // Hand-picked words: alphabet extremes, shifts, abbreviations, end marks.
   task automatic test_directed();
      send_word(16'h0000, 1'b1);
      send_word(pack_word(1'b0, 5'd6, 5'd31, 5'd0), 1'b0);
      // A shift at the end of a word carries into the next word.
      send_word(pack_word(1'b0, 5'd4, 5'd6, 5'd5), 1'b0);
      send_word(pack_word(1'b0, 5'd31, 5'd5, 5'd6), 1'b0);
      // Two shifts in a row: the later one wins.
      send_word(pack_word(1'b0, 5'd4, 5'd5, 5'd31), 1'b0);
      send_word(pack_word(1'b0, 5'd5, 5'd4, 5'd31), 1'b0);
      // Abbreviations in every bank, completed within and across words.
      send_word(pack_word(1'b0, 5'd1, 5'd0, 5'd2), 1'b0);
      send_word(pack_word(1'b0, 5'd31, 5'd3, 5'd31), 1'b0);
      // An abbreviation start drops a pending shift.
      send_word(pack_word(1'b0, 5'd5, 5'd1, 5'd7), 1'b0);
      send_word(pack_word(1'b0, 5'd4, 5'd2, 5'd4), 1'b0);
      send_word(pack_word(1'b0, 5'd6, 5'd5, 5'd1), 1'b0);
      send_word(pack_word(1'b0, 5'd5, 5'd6, 5'd6), 1'b0);
      // A space drops a pending shift.
      send_word(pack_word(1'b0, 5'd4, 5'd0, 5'd6), 1'b0);
      // State left after an end word survives until a new string starts.
      send_word(pack_word(1'b1, 5'd6, 5'd6, 5'd4), 1'b0);
      send_word(pack_word(1'b0, 5'd6, 5'd6, 5'd6), 1'b0);
      send_word(pack_word(1'b1, 5'd0, 5'd0, 5'd1), 1'b0);
      send_word(pack_word(1'b0, 5'd6, 5'd6, 5'd6), 1'b0);
      send_word(pack_word(1'b1, 5'd3, 5'd5, 5'd3), 1'b0);
      send_word(pack_word(1'b0, 5'd6, 5'd7, 5'd8), 1'b1);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h7FFF, 1'b1);
      send_word(16'h8000, 1'b1);
   endtask

   // Strings of random words, mostly well formed, with some noise.
   task automatic test_random_strings(input int n_items);
      int sent;
      int len;
      int flavor;
      logic ns;
      logic fin;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) == 0) req_idle = ~req_idle;
         if ($urandom_range(0, 9) == 0) rsp_idle = ~rsp_idle;
         len = $urandom_range(1, 6);
         flavor = $urandom_range(0, 9);
         for (int j = 0; j < len; j++) begin
            if (flavor == 0) begin
               send_word(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            end else begin
               // A broken string may miss its start flag or its end mark.
               ns  = (j == 0) && (flavor != 1);
               fin = (j == len - 1) && (flavor != 2);
               send_word(pack_word(fin, rand_zchar(), rand_zchar(), rand_zchar()), ns);
            end
            sent++;
         end
      end
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   // The receiver holds off while words keep coming, so the block fills and stalls.
   task automatic test_backpressure();
      req_idle = 1'b0;
      rsp_hold = 60;
      for (int i = 0; i < 40; i++) begin
         send_word(pack_word(1'($urandom_range(0, 1)), rand_zchar(), rand_zchar(),
                             rand_zchar()), i == 0);
      end
      req_idle = 1'b1;
   endtask

   // Full rate on both sides.
   task automatic test_full_rate();
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      for (int i = 0; i < 200; i++) begin
         send_word(pack_word(1'($urandom_range(0, 1)), rand_zchar(), rand_zchar(),
                             rand_zchar()), $urandom_range(0, 7) == 0);
      end
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   initial begin
      clock = 1'b0;
      reset <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.code_word  <= '0;
      req_bus.new_string <= 1'b0;
      rsp_bus.ready      <= 1'b0;
      alpha_sel = ztwd_pkg::SHIFT_LOWER;
      open_bank = ztwd_pkg::NO_BANK;
      mismatches = 0;
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      rsp_hold = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_strings(700);
      test_backpressure();
      test_full_rate();
      test_random_strings(640);
      req_bus.valid <= 1'b0;

      // Drain the block, then allow for its latency.
      while (due_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(LIMIT_NS);
      $display("status: fail");
      $finish;
   end

endmodule

### zscii_text_word_decoder.f
+incdir+rtl
rtl/ztwd_pkg.sv
rtl/ztwd_req_if.sv
rtl/ztwd_rsp_if.sv
rtl/zscii_text_word_decoder.sv
tb/sv/tb.sv
